### hdl/segment_grid_collision_check_assert.svh
// Assertion macros for the segment grid collision check.
// No dependencies; included by the port checker.
`ifndef SEGMENT_GRID_COLLISION_CHECK_ASSERT_SVH
`define SEGMENT_GRID_COLLISION_CHECK_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SGCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment_grid_collision_check: assertion failed");

// Next-cycle implication, disabled in reset.
`define SGCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment_grid_collision_check: assertion failed");

`endif

### hdl/sgcc_pkg.sv
// Shared types and constants for the segment grid collision check.
// No dependencies.
`default_nettype none
package sgcc_pkg;

    localparam int COORD_W    = 20;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int INC_FRAC   = 16;
    localparam int MIN_STEPS  = 10;
    localparam int MAP_W      = 10;
    localparam int SPACING_W  = 11;
    localparam int CELL_W     = 9;
    localparam int IDX_W      = 13;
    localparam int CFG_ADDR_W = 2;
    localparam int SD_W       = 104;
    localparam int MD_W       = 8;

    // Input tdata layout, lowest bit first.
    localparam int ROW_LSB = 0;
    localparam int COL_LSB = ROW_LSB + CELL_W;
    localparam int OCC_BIT = COL_LSB + CELL_W;
    localparam int SX_LSB  = OCC_BIT + 1;
    localparam int SY_LSB  = SX_LSB + COORD_W;
    localparam int EX_LSB  = SY_LSB + COORD_W;
    localparam int EY_LSB  = EX_LSB + COORD_W;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MAP_ROWS = 2'd0,
        CFG_MAP_COLS = 2'd1,
        CFG_SPACING  = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQUARE,
        ST_SUM,
        ST_SQRT,
        ST_QDIV,
        ST_STEPS,
        ST_INCDIV,
        ST_SAMPLE,
        ST_DONE
    } t_state;

    // Tag that travels with one sample through the read pipeline.
    typedef struct packed {
        logic vld;
        logic off;
        logic last;
    } t_smp_tag;

endpackage
`default_nettype wire

### hdl/sgcc_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// No package dependencies.
`default_nettype none
module sgcc_isqrt #(
    parameter int IN_W = 44
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [IN_W-1:0]     i_rad,
    output logic                o_done,
    output logic [IN_W/2-1:0]   o_root
);
    localparam int RT_W  = IN_W / 2;
    localparam int RM_W  = RT_W + 3;
    localparam int CNT_W = $clog2(RT_W + 1);

    logic [IN_W-1:0]  r_rad;
    logic [RM_W-1:0]  r_rem;
    logic [RT_W-1:0]  r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [RM_W-1:0]  w_rem_sh;
    logic [RM_W:0]    w_diff;

    assign w_rem_sh = {r_rem[RM_W-3:0], r_rad[IN_W-1 -: 2]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(RT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[IN_W-3:0], 2'b00};
            if (!w_diff[RM_W]) begin
                r_rem  <= w_diff[RM_W-1:0];
                r_root <= {r_root[RT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[RT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

### hdl/sgcc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No package dependencies.
`default_nettype none
module sgcc_div #(
    parameter int NW = 37,
    parameter int DW = 27
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CNT_W = $clog2(NW + 1);

    logic [DW-1:0]    r_rem;
    logic [NW-1:0]    r_quo;
    logic [DW-1:0]    r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DW:0]      w_sh;
    logic [DW+1:0]    w_diff;

    assign w_sh   = {r_rem, r_quo[NW-1]};
    assign w_diff = {1'b0, w_sh} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[DW+1]) begin
                r_rem <= w_diff[DW-1:0];
                r_quo <= {r_quo[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[DW-1:0];
                r_quo <= {r_quo[NW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule
`default_nettype wire

### hdl/sgcc_grid.sv
// One-bit occupancy grid memory: one write port, one registered read port.
// No package dependencies.
`default_nettype none
module sgcc_grid #(
    parameter int AW = 18
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic          i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic          o_rd_data
);
    logic r_mem [2**AW];
    logic r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

### hdl/segment_grid_collision_check.sv
// Segment collision check against a one-bit occupancy grid.
// Cell write: no result. Query: setup (square root, step division, increment division,
// plus handoff) then one grid read per sample, steps+1 samples at most, then the read
// pipeline and the output register; one query at a time.
// Reset (synchronous, active low) clears control state and loads the map size 512 x 512
// and spacing 50; grid contents are undefined until written and are never cleared.
// Depends on sgcc_pkg, sgcc_isqrt, sgcc_div and sgcc_grid.
`default_nettype none
module segment_grid_collision_check #(
    parameter int GRID_ROWS_MAX   = 512,
    parameter int GRID_COLS_MAX   = 512,
    parameter int MAX_STEPS       = 8191,
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // cell_row[8:0], cell_col[17:9], cell_occupied[18], start_x[38:19],
    // start_y[58:39], end_x[78:59], end_y[98:79], zero pad[103:99]
    input  logic [sgcc_pkg::SD_W-1:0]       i_s_tdata,
    // func[0]: 0 write a cell, 1 query a segment
    input  logic                            i_s_tuser,
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // collided[0], zero pad[7:1]
    output logic [sgcc_pkg::MD_W-1:0]       o_m_tdata,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sgcc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [sgcc_pkg::SPACING_W-1:0]  i_cfg_data
);
    import sgcc_pkg::*;

    localparam int RB     = $clog2(GRID_ROWS_MAX);
    localparam int CB     = $clog2(GRID_COLS_MAX);
    localparam int AW     = RB + CB;
    localparam int SW     = $clog2(MAX_STEPS + 1);
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int RAD_W  = SQ_W + 2;
    localparam int RT_W   = RAD_W / 2;
    localparam int SPF_W  = SPACING_W + COORD_FRAC_BITS;
    localparam int DVS_W  = (SPF_W > SW) ? SPF_W : SW;
    localparam int NW     = DIFF_W + INC_FRAC;
    localparam int ACC_W  = COORD_W + INC_FRAC + 2;
    localparam int SH     = COORD_FRAC_BITS + INC_FRAC;
    localparam int IP_W   = ACC_W - SH;
    localparam int CMP_W  = ((IP_W > IDX_W) ? IP_W : IDX_W) + 1;

    // ---------------------------------------------------------------
    // Configuration registers; the channel never stalls.
    // ---------------------------------------------------------------
    logic [MAP_W-1:0]     r_map_rows;
    logic [MAP_W-1:0]     r_map_cols;
    logic [SPACING_W-1:0] r_spacing;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_rows <= MAP_W'(512);
            r_map_cols <= MAP_W'(512);
            r_spacing  <= SPACING_W'(50);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_MAP_ROWS: r_map_rows <= i_cfg_data[MAP_W-1:0];
                CFG_MAP_COLS: r_map_cols <= i_cfg_data[MAP_W-1:0];
                CFG_SPACING:  r_spacing  <= i_cfg_data;
                default:      ;  // unknown index: drop the write
            endcase
        end
    end

    // Saturate the map size to the grid; zero spacing acts as one.
    localparam logic [IDX_W-1:0] ROWS_LIM = IDX_W'(GRID_ROWS_MAX);
    localparam logic [IDX_W-1:0] COLS_LIM = IDX_W'(GRID_COLS_MAX);

    logic [IDX_W-1:0]     w_rows_ext;
    logic [IDX_W-1:0]     w_cols_ext;
    logic [IDX_W-1:0]     w_rows;
    logic [IDX_W-1:0]     w_cols;
    logic [SPACING_W-1:0] w_spacing;

    assign w_rows_ext = IDX_W'(r_map_rows);
    assign w_cols_ext = IDX_W'(r_map_cols);
    assign w_rows     = (w_rows_ext > ROWS_LIM) ? ROWS_LIM : w_rows_ext;
    assign w_cols     = (w_cols_ext > COLS_LIM) ? COLS_LIM : w_cols_ext;
    assign w_spacing  = (r_spacing == '0) ? SPACING_W'(1) : r_spacing;

    // ---------------------------------------------------------------
    // Input fields
    // ---------------------------------------------------------------
    logic [IDX_W-1:0]          w_in_row;
    logic [IDX_W-1:0]          w_in_col;
    logic                      w_in_occ;
    logic                      w_in_accept;
    logic                      w_cell_wr;

    assign w_in_row    = IDX_W'(i_s_tdata[ROW_LSB +: CELL_W]);
    assign w_in_col    = IDX_W'(i_s_tdata[COL_LSB +: CELL_W]);
    assign w_in_occ    = i_s_tdata[OCC_BIT];
    assign w_in_accept = i_s_tvalid && o_s_tready;
    // Drop writes that fall outside the grid.
    assign w_cell_wr   = w_in_accept && (t_func'(i_s_tuser) == FUNC_WRITE)
                         && (w_in_row < ROWS_LIM) && (w_in_col < COLS_LIM);

    // ---------------------------------------------------------------
    // Control state machine
    // ---------------------------------------------------------------
    t_state r_state;
    t_state n_state;
    logic   w_sq_start;
    logic   w_da_start;
    logic   w_db_start;
    logic   w_out_load;
    logic   w_sq_done;
    logic   w_da_done;
    logic   w_db_done;
    logic   w_finish;
    logic   w_out_free;

    assign w_out_free = !o_m_tvalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_sq_start = 1'b0;
        w_da_start = 1'b0;
        w_db_start = 1'b0;
        w_out_load = 1'b0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid && (t_func'(i_s_tuser) == FUNC_QUERY)) begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF:   n_state = ST_SQUARE;
            ST_SQUARE: n_state = ST_SUM;
            ST_SUM: begin
                w_sq_start = 1'b1;
                n_state    = ST_SQRT;
            end
            ST_SQRT: begin
                if (w_sq_done) begin
                    w_da_start = 1'b1;
                    n_state    = ST_QDIV;
                end
            end
            ST_QDIV: begin
                if (w_da_done) begin
                    n_state = ST_STEPS;
                end
            end
            ST_STEPS: begin
                w_da_start = 1'b1;
                w_db_start = 1'b1;
                n_state    = ST_INCDIV;
            end
            ST_INCDIV: begin
                if (w_da_done) begin
                    n_state = ST_SAMPLE;
                end
            end
            ST_SAMPLE: begin
                if (w_finish) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Setup datapath: length, step count and per-sample increments
    // ---------------------------------------------------------------
    logic signed [COORD_W-1:0] r_sx, r_sy, r_ex, r_ey;
    logic signed [DIFF_W-1:0]  r_dx, r_dy;
    logic        [SQ_W-1:0]    r_sqx, r_sqy;
    logic        [SW-1:0]      r_steps;
    logic signed [ACC_W-1:0]   r_inc_x, r_inc_y;
    logic signed [ACC_W-1:0]   r_acc_x, r_acc_y;

    logic signed [SQ_W-1:0]    w_sqx, w_sqy;
    logic        [RAD_W-1:0]   w_rad;
    logic        [RT_W-1:0]    w_root;
    logic        [DIFF_W-1:0]  w_adx, w_ady;
    logic        [NW-1:0]      w_da_num;
    logic        [DVS_W-1:0]   w_da_dvs;
    logic        [NW-1:0]      w_da_quot, w_db_quot;
    logic        [DVS_W-1:0]   w_steps_dvs;

    assign w_sqx = r_dx * r_dx;
    assign w_sqy = r_dy * r_dy;
    assign w_rad = RAD_W'(r_sqx) + RAD_W'(r_sqy);
    assign w_adx = r_dx[DIFF_W-1] ? DIFF_W'(-r_dx) : DIFF_W'(r_dx);
    assign w_ady = r_dy[DIFF_W-1] ? DIFF_W'(-r_dy) : DIFF_W'(r_dy);
    assign w_steps_dvs = DVS_W'(r_steps);

    // Divider A first finds root / (spacing << frac), then |dx| << 16 / steps.
    always_comb begin
        if (r_state == ST_SQRT) begin
            w_da_num = NW'(w_root);
            w_da_dvs = DVS_W'(w_spacing) << COORD_FRAC_BITS;
        end else begin
            w_da_num = {w_adx, {INC_FRAC{1'b0}}};
            w_da_dvs = w_steps_dvs;
        end
    end

    sgcc_isqrt #(
        .IN_W (RAD_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_rad   (w_rad),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    sgcc_div #(
        .NW (NW),
        .DW (DVS_W)
    ) u_div_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_da_start),
        .i_dividend (w_da_num),
        .i_divisor  (w_da_dvs),
        .o_done     (w_da_done),
        .o_quot     (w_da_quot)
    );

    sgcc_div #(
        .NW (NW),
        .DW (DVS_W)
    ) u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_db_start),
        .i_dividend ({w_ady, {INC_FRAC{1'b0}}}),
        .i_divisor  (w_steps_dvs),
        .o_done     (w_db_done),
        .o_quot     (w_db_quot)
    );

    // ---------------------------------------------------------------
    // Sample walk: address stage, grid read stage, check stage
    // ---------------------------------------------------------------
    logic        [SW-1:0]     r_idx;
    logic                     r_issue;
    t_smp_tag                 r_p1, r_p2;
    logic        [AW-1:0]     r_p1_addr;
    logic                     r_hit;
    logic                     r_m_tvalid;
    logic                     r_m_coll;

    logic signed [IP_W-1:0]   w_ipx, w_ipy;
    logic                     w_cx, w_cy;
    logic signed [CMP_W-1:0]  w_tx, w_ty;
    logic        [CMP_W-1:0]  w_row;
    logic                     w_off;
    logic                     w_rd_data;
    logic                     w_hit;

    // Truncate toward zero: a negative value with a fraction moves up by one.
    assign w_ipx = r_acc_x[ACC_W-1:SH];
    assign w_ipy = r_acc_y[ACC_W-1:SH];
    assign w_cx  = r_acc_x[ACC_W-1] && (|r_acc_x[SH-1:0]);
    assign w_cy  = r_acc_y[ACC_W-1] && (|r_acc_y[SH-1:0]);
    assign w_tx  = {{(CMP_W-IP_W){w_ipx[IP_W-1]}}, w_ipx} + {{(CMP_W-1){1'b0}}, w_cx};
    assign w_ty  = {{(CMP_W-IP_W){w_ipy[IP_W-1]}}, w_ipy} + {{(CMP_W-1){1'b0}}, w_cy};
    // Rows are flipped: grid row = rows - 1 - y.
    assign w_row = CMP_W'(w_rows) - CMP_W'(1) - w_ty;
    assign w_off = w_tx[CMP_W-1] || (w_tx >= CMP_W'(w_cols))
                || w_ty[CMP_W-1] || (w_ty >= CMP_W'(w_rows));

    assign w_hit    = r_p2.vld && (r_p2.off || w_rd_data);
    assign w_finish = w_hit || (r_p2.vld && r_p2.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_p1    <= '0;
            r_p2    <= '0;
        end else begin
            // Hold the walk to the sampling state; leaving it flushes the pipe.
            r_p1.vld  <= (r_state == ST_SAMPLE) && r_issue && !w_finish;
            r_p1.off  <= w_off;
            r_p1.last <= (r_idx == r_steps);
            r_p2.vld  <= (r_state == ST_SAMPLE) && r_p1.vld && !w_finish;
            r_p2.off  <= r_p1.off;
            r_p2.last <= r_p1.last;
            if ((r_state == ST_INCDIV) && w_da_done) begin
                r_issue <= 1'b1;
            end else if ((r_state != ST_SAMPLE) || w_finish
                         || (r_issue && (r_idx == r_steps))) begin
                r_issue <= 1'b0;
            end
        end
    end

    // Payload registers, advanced per state.
    always_ff @(posedge i_clk) begin
        r_p1_addr <= {w_row[RB-1:0], w_tx[CB-1:0]};
        case (r_state)
            ST_IDLE: begin
                r_sx <= i_s_tdata[SX_LSB +: COORD_W];
                r_sy <= i_s_tdata[SY_LSB +: COORD_W];
                r_ex <= i_s_tdata[EX_LSB +: COORD_W];
                r_ey <= i_s_tdata[EY_LSB +: COORD_W];
            end
            ST_DIFF: begin
                r_dx <= DIFF_W'(r_ex) - DIFF_W'(r_sx);
                r_dy <= DIFF_W'(r_ey) - DIFF_W'(r_sy);
            end
            ST_SQUARE: begin
                r_sqx <= w_sqx;
                r_sqy <= w_sqy;
            end
            ST_QDIV: begin
                // Clamp the step count into [MIN_STEPS, MAX_STEPS].
                if (w_da_quot < NW'(MIN_STEPS)) begin
                    r_steps <= SW'(MIN_STEPS);
                end else if (w_da_quot > NW'(MAX_STEPS)) begin
                    r_steps <= SW'(MAX_STEPS);
                end else begin
                    r_steps <= w_da_quot[SW-1:0];
                end
            end
            ST_INCDIV: begin
                r_inc_x <= r_dx[DIFF_W-1] ? -ACC_W'(w_da_quot) : ACC_W'(w_da_quot);
                r_inc_y <= r_dy[DIFF_W-1] ? -ACC_W'(w_db_quot) : ACC_W'(w_db_quot);
                r_acc_x <= {{(ACC_W-COORD_W-INC_FRAC){r_sx[COORD_W-1]}}, r_sx,
                            {INC_FRAC{1'b0}}};
                r_acc_y <= {{(ACC_W-COORD_W-INC_FRAC){r_sy[COORD_W-1]}}, r_sy,
                            {INC_FRAC{1'b0}}};
                r_idx   <= '0;
            end
            ST_SAMPLE: begin
                if (r_issue) begin
                    r_acc_x <= r_acc_x + r_inc_x;
                    r_acc_y <= r_acc_y + r_inc_y;
                    r_idx   <= r_idx + SW'(1);
                end
                if (w_finish) begin
                    r_hit <= w_hit;
                end
            end
            default: ;
        endcase
    end

    // Grid writes happen only when idle, so reads never race a write.
    sgcc_grid #(
        .AW (AW)
    ) u_grid (
        .i_clk     (i_clk),
        .i_wr_en   (w_cell_wr),
        .i_wr_addr ({w_in_row[RB-1:0], w_in_col[CB-1:0]}),
        .i_wr_data (w_in_occ),
        .i_rd_en   (r_p1.vld),
        .i_rd_addr (r_p1_addr),
        .o_rd_data (w_rd_data)
    );

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_coll <= r_hit;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {{(MD_W-1){1'b0}}, r_m_coll};

    // Divider B runs in lockstep with divider A; its done is not needed.
    logic w_unused;
    assign w_unused = w_db_done;
endmodule
`default_nettype wire

### hdl/sgcc_checker.sv
`include "segment_grid_collision_check_assert.svh"
// Port-level checker for the segment grid collision check, bound to the top level.
// Depends on sgcc_pkg and the assertion macro header.
`default_nettype none
module sgcc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [sgcc_pkg::SD_W-1:0]       i_s_tdata,
    input logic                            i_s_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [sgcc_pkg::MD_W-1:0]       o_m_tdata,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [sgcc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input logic [sgcc_pkg::SPACING_W-1:0]  i_cfg_data
);
    import sgcc_pkg::*;

    logic w_q_acc;
    logic w_w_acc;
    logic w_unused;

    assign w_q_acc  = i_s_tvalid && o_s_tready && (t_func'(i_s_tuser) == FUNC_QUERY);
    assign w_w_acc  = i_s_tvalid && o_s_tready && (t_func'(i_s_tuser) == FUNC_WRITE);
    assign w_unused = ^{i_s_tdata, i_cfg_valid, o_cfg_ready, i_cfg_addr, i_cfg_data};

    // A stalled result stays and holds its value.
    `SGCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    // Only the collided bit may be set.
    `SGCC_ASSERT_NOW(a_out_pad, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[MD_W-1:1] == '0)
    // A query occupies the block: input stalls right after it.
    `SGCC_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, w_q_acc, !o_s_tready)
    // A cell write leaves the block ready in the cycle after it.
    `SGCC_ASSERT_NEXT(a_write_quick, i_clk, i_rst_n, w_w_acc, o_s_tready)
endmodule

bind segment_grid_collision_check sgcc_checker u_sgcc_checker (.*);
`default_nettype wire

### tb/segment_grid_collision_check_checker.sv
// Checker for the segment grid collision check: watches the input, result and
// configuration channels, predicts every collision flag and compares.
// Depends on sgcc_pkg.
`timescale 1ns / 100ps
module segment_grid_collision_check_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [sgcc_pkg::SD_W-1:0]       i_s_tdata,
    input  logic                            i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [sgcc_pkg::MD_W-1:0]       i_m_tdata,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [sgcc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [sgcc_pkg::SPACING_W-1:0]  i_cfg_data,
    output int                              o_err_count,
    output int                              o_pending
);
    import sgcc_pkg::*;

    localparam int GRID_N = 512;

    bit          occ_map [0:GRID_N*GRID_N-1];
    logic [9:0]  rows_reg;
    logic [9:0]  cols_reg;
    logic [10:0] spacing_reg;
    bit          collide_q [$];

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic bit predict_collision(logic signed [19:0] sx, logic signed [19:0] sy,
                                             logic signed [19:0] ex, logic signed [19:0] ey);
        longint dx, dy, steps, inc_x, inc_y, ax, ay, rows, cols, col, row, sp;
        longint unsigned d2;
        dx = longint'(ex) - longint'(sx);
        dy = longint'(ey) - longint'(sy);
        d2 = dx * dx + dy * dy;
        sp = (spacing_reg == 0) ? 1 : longint'(spacing_reg);
        steps = longint'(int_sqrt(d2) / (sp << 8));
        if (steps < MIN_STEPS) steps = MIN_STEPS;
        if (steps > 8191) steps = 8191;
        inc_x = (dx * 65536) / steps;
        inc_y = (dy * 65536) / steps;
        rows = (rows_reg > GRID_N) ? GRID_N : longint'(rows_reg);
        cols = (cols_reg > GRID_N) ? GRID_N : longint'(cols_reg);
        ax = longint'(sx) * 65536;
        ay = longint'(sy) * 65536;
        for (longint i = 0; i <= steps; i++) begin
            col = ax / (longint'(1) << 24);
            row = rows - ay / (longint'(1) << 24) - 1;
            // off the map counts as a hit; negative fractions truncate to zero
            if (row < 0 || row >= rows || col < 0 || col >= cols) return 1'b1;
            if (occ_map[row * GRID_N + col]) return 1'b1;
            ax += inc_x;
            ay += inc_y;
        end
        return 1'b0;
    endfunction

    assign o_pending = collide_q.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_reg    <= 10'd512;
            cols_reg    <= 10'd512;
            spacing_reg <= 11'd50;
            collide_q.delete();
            o_err_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_MAP_ROWS: rows_reg    <= i_cfg_data[9:0];
                    CFG_MAP_COLS: cols_reg    <= i_cfg_data[9:0];
                    CFG_SPACING:  spacing_reg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (t_func'(i_s_tuser) == FUNC_WRITE)
                    occ_map[int'(i_s_tdata[ROW_LSB +: CELL_W]) * GRID_N +
                            int'(i_s_tdata[COL_LSB +: CELL_W])] = i_s_tdata[OCC_BIT];
                else
                    collide_q.push_back(predict_collision(i_s_tdata[SX_LSB +: COORD_W],
                        i_s_tdata[SY_LSB +: COORD_W], i_s_tdata[EX_LSB +: COORD_W],
                        i_s_tdata[EY_LSB +: COORD_W]));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (collide_q.size() == 0) begin
                    if (o_err_count < 10)
                        $display("result without query: collided=%0b", i_m_tdata[0]);
                    o_err_count <= o_err_count + 1;
                end else begin
                    if (collide_q[0] !== i_m_tdata[0]) begin
                        if (o_err_count < 10)
                            $display("collided mismatch: expected %0b actual %0b",
                                     collide_q[0], i_m_tdata[0]);
                        o_err_count <= o_err_count + 1;
                    end
                    void'(collide_q.pop_front());
                end
            end
        end
    end
endmodule

### tb/tb_segment_grid_collision_check.sv
// Top of the segment grid collision check testbench: clock, reset, stimulus
// and verdict. Depends on sgcc_pkg, the block and the checker module.
`timescale 1ns / 100ps
module tb_segment_grid_collision_check;
    import sgcc_pkg::*;

    // Corner window of the grid that is loaded before any query reads it.
    localparam int WIN = 24;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [SD_W-1:0]       s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [MD_W-1:0]       m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [SPACING_W-1:0]  cfg_data = '0;
    int                    err_count;
    int                    pending;
    int                    results_seen = 0;
    int                    cur_rows = 512;
    int                    cur_cols = 512;

    always #6 i_clk = ~i_clk;

    segment_grid_collision_check i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data)
    );

    segment_grid_collision_check_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .o_err_count(err_count), .o_pending(pending)
    );

    // Mostly short gaps, a few long ones, and plenty of back-to-back stretches.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // Result side: random stalls, plus one long hold-off once results flow,
    // so the block fills up and pushes back on the input.
    initial begin
        int hold;
        bit held;
        held = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 30) begin
                held = 1'b1;
                m_tready = 1'b0;
                for (hold = 0; hold < 600; hold++) @(negedge i_clk);
            end
            if ($urandom_range(0, 99) < 70) m_tready = 1'b1;
            else m_tready = (gap_len() == 0);
        end
    end

    always @(posedge i_clk)
        if (m_tvalid && m_tready) results_seen <= results_seen + 1;

    // Offer one transaction on the input stream and hold it until accepted.
    task automatic send_item(t_func fn, logic [SD_W-1:0] data, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            s_tvalid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = fn;
        s_tdata  = data;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cell(int row, int col, bit occ, bit no_gap);
        logic [SD_W-1:0] d;
        d = SD_W'({$urandom, $urandom, $urandom, $urandom});
        d[SD_W-1:EY_LSB+COORD_W] = '0;
        d[ROW_LSB +: CELL_W] = CELL_W'(row);
        d[COL_LSB +: CELL_W] = CELL_W'(col);
        d[OCC_BIT] = occ;
        send_item(FUNC_WRITE, d, no_gap);
    endtask

    task automatic query_seg(int sx, int sy, int ex, int ey);
        logic [SD_W-1:0] d;
        d = SD_W'({$urandom, $urandom, $urandom, $urandom});
        d[SD_W-1:EY_LSB+COORD_W] = '0;
        d[SX_LSB +: COORD_W] = COORD_W'(sx);
        d[SY_LSB +: COORD_W] = COORD_W'(sy);
        d[EX_LSB +: COORD_W] = COORD_W'(ex);
        d[EY_LSB +: COORD_W] = COORD_W'(ey);
        send_item(FUNC_QUERY, d, 1'b0);
    endtask

    task automatic write_reg(t_cfg_idx idx, int value);
        cfg_valid = 1'b1;
        cfg_addr  = idx;
        cfg_data  = SPACING_W'(value);
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // Drain every outstanding query, then let the pipeline settle.
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Track the map size in effect, saturated to the grid.
    task automatic set_map(int rows, int cols, int spacing);
        wait_idle();
        write_reg(CFG_MAP_ROWS, rows);
        write_reg(CFG_MAP_COLS, cols);
        write_reg(CFG_SPACING, spacing);
        cur_rows = (rows > 512) ? 512 : rows;
        cur_cols = (cols > 512) ? 512 : cols;
    endtask

    // Any 20-bit coordinate.
    function automatic int any_coord();
        int v;
        v = int'($urandom_range(0, 32'hFFFFF));
        return (v << 12) >>> 12;
    endfunction

    // Coordinate that truncates into [0, cells), negative fractions included.
    function automatic int in_coord(int cells);
        return int'($urandom_range(0, cells * 256 + 254)) - 255;
    endfunction

    // Coordinate that truncates outside [0, cells).
    function automatic int off_coord(int cells);
        if ($urandom_range(0, 1) == 0)
            return cells * 256 + int'($urandom_range(0, 524287 - cells * 256));
        return -256 - int'($urandom_range(0, 524032));
    endfunction

    // Queries either stay inside the loaded window or start off the map,
    // so no sample ever reads a cell that was never written.
    task automatic random_items(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 30) begin
                if ($urandom_range(0, 99) < 80)
                    write_cell(int'($urandom_range(0, WIN - 1)),
                               int'($urandom_range(0, WIN - 1)),
                               $urandom_range(0, 99) < 15, 1'b0);
                else
                    write_cell(int'($urandom_range(0, 511)), int'($urandom_range(0, 511)),
                               $urandom_range(0, 99) < 15, 1'b0);
            end else if (cur_rows == 0 || cur_cols == 0) begin
                query_seg(any_coord(), any_coord(), any_coord(), any_coord());
            end else if (cur_rows <= WIN && cur_cols <= WIN
                         && $urandom_range(0, 99) < 85) begin
                query_seg(in_coord(cur_cols), in_coord(cur_rows),
                          in_coord(cur_cols), in_coord(cur_rows));
            end else if ($urandom_range(0, 1) == 0) begin
                query_seg(off_coord(cur_cols), any_coord(), any_coord(), any_coord());
            end else begin
                query_seg(any_coord(), off_coord(cur_rows), any_coord(), any_coord());
            end
        end
    endtask

    initial begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Load every cell of the corner window once; queries only read inside it.
        for (int r = 0; r < WIN; r++)
            for (int c = 0; c < WIN; c++)
                write_cell(r, c, $urandom_range(0, 99) < 10, 1'b1);

        set_map(WIN, WIN, 50);
        // Directed: corner cells, extreme coordinates, zero length, negative fractions.
        write_cell(0, 0, 1'b1, 1'b0);
        write_cell(WIN - 1, WIN - 1, 1'b1, 1'b0);
        write_cell(0, WIN - 1, 1'b0, 1'b0);
        write_cell(WIN - 1, 0, 1'b0, 1'b0);
        write_cell(511, 511, 1'b1, 1'b0);
        write_cell(10, 5, 1'b1, 1'b0);
        query_seg(0, 0, 0, 0);
        query_seg(-128, -128, -64, -32);
        query_seg(-524288, -524288, 524287, 524287);
        query_seg(524287, 0, -524288, 0);
        query_seg(23 * 256 + 255, 128, 23 * 256, 0);
        query_seg(0, 23 * 256 + 128, 23 * 256, 23 * 256);
        query_seg(5 * 256 + 10, 13 * 256, 5 * 256 + 100, 13 * 256 + 50);
        query_seg(-1, 10 * 256, 20 * 256, 10 * 256);
        query_seg(10 * 256, 24 * 256, 10 * 256, 23 * 256);
        query_seg(24 * 256, 10 * 256, 23 * 256, 10 * 256);
        query_seg(0, 0, 23 * 256 + 255, 23 * 256 + 255);
        query_seg(-255, -255, 23 * 256 + 255, 23 * 256 + 255);
        write_cell(10, 5, 1'b0, 1'b0);

        set_map(WIN, WIN, 50);
        random_items(150);
        set_map(20, 17, 1);
        random_items(110);
        // Oversized map and widest spacing.
        set_map(1023, 1023, 2047);
        random_items(50);
        // Empty map: every sample is off it; zero spacing acts as one.
        set_map(0, 5, 0);
        query_seg(0, 0, 0, 0);
        random_items(30);
        set_map(1, 1, 1);
        query_seg(64, 64, 200, 100);
        random_items(30);
        set_map(WIN, WIN, 1);
        random_items(80);
        set_map(8, WIN, 1024);
        random_items(40);
        set_map(WIN, WIN, 50);
        random_items(30);

        wait_idle();
        if (err_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
